// ----- rtl/fmh_pkg.sv -----
`default_nettype none

package fmh_pkg;

  // Slot count; kept a power of two so the home slot is the low hash bits.
  localparam int unsigned TABLE_SLOTS = 64;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

  localparam int unsigned SIZE_W   = 24;
  localparam int unsigned WEIGHT_W = 8;
  localparam int unsigned QSIZE_W  = 20;
  localparam int unsigned KEY_W    = QSIZE_W + WEIGHT_W;
  localparam int unsigned METRIC_W = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic CMD_INSERT = 1'b1;

  localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [STATUS_W-1:0] {
    ST_MISS   = 2'd0,
    ST_HIT    = 2'd1,
    ST_STORED = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Operand pair for the shared 32x32 multiplier.
  typedef enum logic [2:0] {
    MS_K1_LO = 3'd0,
    MS_K1_HI = 3'd1,
    MS_K2_LL = 3'd2,
    MS_K2_LH = 3'd3,
    MS_K2_HL = 3'd4
  } mul_sel_e;

  typedef enum logic [1:0] {
    AO_HOLD   = 2'd0,
    AO_LOAD   = 2'd1,
    AO_ADD_HI = 2'd2
  } acc_op_e;

  typedef struct packed {
    logic     capture;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     x_load;
    logic     slot_load;
    logic     slot_inc;
    logic     clr;
    logic     key_we;
    logic     data_we;
    logic     res_load;
    logic     res_hit;
    status_e  res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic key_empty;
    logic key_match;
    logic last_probe;
    logic last_slot;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/fmh_ram.sv -----
`default_nettype none

module fmh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/fmh_dp.sv -----
`default_nettype none

module fmh_dp
  import fmh_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dp_cmd_t                    cmd_i,
  output dp_sts_t                         sts_o,
  input  wire logic                       cmd_in_i,
  input  wire logic [SIZE_W-1:0]          size_fx_i,
  input  wire logic [WEIGHT_W-1:0]        weight_i,
  input  wire logic signed [METRIC_W-1:0] ascent_in_i,
  input  wire logic signed [METRIC_W-1:0] height_in_i,
  output logic [STATUS_W-1:0]             status_o,
  output logic signed [METRIC_W-1:0]      ascent_out_o,
  output logic signed [METRIC_W-1:0]      height_out_o,
  output logic                            key_we_o,
  output logic [SLOT_W-1:0]               ram_addr_o,
  output logic [KEY_W-1:0]                key_wdata_o,
  input  wire logic [KEY_W-1:0]           key_rdata_i,
  output logic                            data_we_o,
  output logic [2*METRIC_W-1:0]           data_wdata_o,
  input  wire logic [2*METRIC_W-1:0]      data_rdata_i
);

  logic                is_ins_q;
  logic [KEY_W-1:0]    key_q;
  logic [METRIC_W-1:0] asc_q, hgt_q;
  logic [63:0]         prod_q, acc_q, x_q;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [SLOT_W-1:0]   cnt_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [METRIC_W-1:0] res_asc_q, res_hgt_q;

  logic [SIZE_W:0]     size_rnd;
  logic [QSIZE_W:0]    q_raw;
  logic [QSIZE_W-1:0]  q_sat;
  logic [KEY_W-1:0]    key_new;
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         sum, mixed;

  // Round to 1/16 px, saturate so the key stays 28 bits.
  assign size_rnd = {1'b0, size_fx_i} + (SIZE_W+1)'(8);
  assign q_raw    = size_rnd[SIZE_W:4];
  assign q_sat    = q_raw[QSIZE_W] ? '1 : q_raw[QSIZE_W-1:0];
  assign key_new  = {q_sat, weight_i};

  always_comb begin
    mul_a = {{(32-KEY_W){1'b0}}, key_q};
    mul_b = FMIX_C1[31:0];
    case (cmd_i.mul_sel)
      MS_K1_LO: begin
        mul_a = {{(32-KEY_W){1'b0}}, key_q};
        mul_b = FMIX_C1[31:0];
      end
      MS_K1_HI: begin
        mul_a = {{(32-KEY_W){1'b0}}, key_q};
        mul_b = FMIX_C1[63:32];
      end
      MS_K2_LL: begin
        mul_a = x_q[31:0];
        mul_b = FMIX_C2[31:0];
      end
      MS_K2_LH: begin
        mul_a = x_q[31:0];
        mul_b = FMIX_C2[63:32];
      end
      MS_K2_HL: begin
        mul_a = x_q[63:32];
        mul_b = FMIX_C2[31:0];
      end
      default: begin
        mul_a = {{(32-KEY_W){1'b0}}, key_q};
        mul_b = FMIX_C1[31:0];
      end
    endcase
  end

  // Cross product lands in the upper word only, mod 2^64.
  assign sum   = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
  assign mixed = sum ^ (sum >> 33);

  assign slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.slot_load) begin
        slot_q <= mixed[SLOT_W-1:0];
        cnt_q  <= '0;
      end else if (cmd_i.slot_inc) begin
        slot_q <= slot_d;
        cnt_q  <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_ins_q <= (cmd_in_i == CMD_INSERT);
      key_q    <= key_new;
      asc_q    <= ascent_in_i;
      hgt_q    <= height_in_i;
    end
    prod_q <= mul_a * mul_b;
    case (cmd_i.acc_op)
      AO_HOLD:   acc_q <= acc_q;
      AO_LOAD:   acc_q <= prod_q;
      AO_ADD_HI: acc_q <= sum;
      default:   acc_q <= acc_q;
    endcase
    if (cmd_i.x_load) begin
      x_q <= mixed;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_asc_q    <= cmd_i.res_hit ? data_rdata_i[2*METRIC_W-1:METRIC_W] : '0;
      res_hgt_q    <= cmd_i.res_hit ? data_rdata_i[METRIC_W-1:0] : '0;
    end
  end

  assign sts_o.is_insert  = is_ins_q;
  assign sts_o.key_empty  = (key_rdata_i == '0);
  assign sts_o.key_match  = (key_rdata_i == key_q);
  assign sts_o.last_probe = (cnt_q == SLOT_LAST);
  assign sts_o.last_slot  = (slot_q == SLOT_LAST);

  assign ram_addr_o   = slot_q;
  assign key_we_o     = cmd_i.key_we;
  assign key_wdata_o  = cmd_i.clr ? '0 : key_q;
  assign data_we_o    = cmd_i.data_we;
  assign data_wdata_o = {asc_q, hgt_q};

  assign status_o     = res_status_q;
  assign ascent_out_o = res_asc_q;
  assign height_out_o = res_hgt_q;

endmodule

`default_nettype wire

// ----- rtl/fmh_ctrl.sv -----
`default_nettype none

module fmh_ctrl
  import fmh_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
    S_PRB_RD, S_PRB_CHK, S_DONE
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    out_valid_q;
  logic    free;

  assign free        = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    st_d    = st_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr    = 1'b1;
        cmd_o.key_we = 1'b1;
        cmd_o.slot_inc = 1'b1;
        if (sts_i.last_slot) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_M1;
        end
      end
      S_M1: begin
        cmd_o.mul_sel = MS_K1_LO;
        state_d = S_M2;
      end
      S_M2: begin
        cmd_o.mul_sel = MS_K1_HI;
        cmd_o.acc_op  = AO_LOAD;
        state_d = S_M3;
      end
      S_M3: begin
        cmd_o.x_load = 1'b1;
        state_d = S_M4;
      end
      S_M4: begin
        cmd_o.mul_sel = MS_K2_LL;
        state_d = S_M5;
      end
      S_M5: begin
        cmd_o.mul_sel = MS_K2_LH;
        cmd_o.acc_op  = AO_LOAD;
        state_d = S_M6;
      end
      S_M6: begin
        cmd_o.mul_sel = MS_K2_HL;
        cmd_o.acc_op  = AO_ADD_HI;
        state_d = S_M7;
      end
      S_M7: begin
        cmd_o.slot_load = 1'b1;
        state_d = S_PRB_RD;
      end
      S_PRB_RD: begin
        state_d = S_PRB_CHK;
      end
      S_PRB_CHK: begin
        if (sts_i.is_insert) begin
          if (sts_i.key_empty || sts_i.key_match) begin
            cmd_o.key_we  = 1'b1;
            cmd_o.data_we = 1'b1;
            st_d    = ST_STORED;
            state_d = S_DONE;
          end else if (sts_i.last_probe) begin
            st_d    = ST_FULL;
            state_d = S_DONE;
          end else begin
            cmd_o.slot_inc = 1'b1;
            state_d = S_PRB_RD;
          end
        end else begin
          if (sts_i.key_empty) begin
            st_d    = ST_MISS;
            state_d = S_DONE;
          end else if (sts_i.key_match) begin
            st_d    = ST_HIT;
            state_d = S_DONE;
          end else if (sts_i.last_probe) begin
            st_d    = ST_MISS;
            state_d = S_DONE;
          end else begin
            cmd_o.slot_inc = 1'b1;
            state_d = S_PRB_RD;
          end
        end
      end
      S_DONE: begin
        // Hold until the result register is free; RAM data stays put.
        if (free) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_hit    = (st_q == ST_HIT);
          cmd_o.res_status = st_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      st_q        <= ST_MISS;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      if (cmd_o.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/font_metric_hash_cache.sv -----
`default_nettype none

// Font metric memo table: 64 slots, open addressing with linear probing.
// Each input beat is a lookup (cmd 0) or an insert/update (cmd 1) keyed by the
// font size rounded to 1/16 px and the weight. After reset the block sweeps the
// key store to empty, one slot a cycle, with in_ready_o low. One item at a
// time is in flight: hashing steps through states S_M1 to S_M7 on a single
// shared 32x32 multiplier (murmur3 fmix64, low word), then each probe is a
// slot read, then a compare, and a done state places the result beat in the
// output register once that register is free. A finished result waits in the
// output register while the next item is accepted. A hit returns the stored
// ascent and height; every other status returns zeros.
// Size 0 with weight 0 forms the empty key and never hits.

module font_metric_hash_cache
  import fmh_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       cmd_i,
  input  wire logic [SIZE_W-1:0]          size_fx_i,
  input  wire logic [WEIGHT_W-1:0]        weight_i,
  input  wire logic signed [METRIC_W-1:0] ascent_in_i,
  input  wire logic signed [METRIC_W-1:0] height_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [STATUS_W-1:0]             status_o,
  output logic signed [METRIC_W-1:0]      ascent_out_o,
  output logic signed [METRIC_W-1:0]      height_out_o
);

  dp_cmd_t              dp_cmd;
  dp_sts_t              dp_sts;
  logic                 key_we, data_we;
  logic [SLOT_W-1:0]    ram_addr;
  logic [KEY_W-1:0]     key_wdata, key_rdata;
  logic [2*METRIC_W-1:0] data_wdata, data_rdata;

  // Sequence the clear sweep, hash steps and probe loop.
  fmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // Key forming, hash arithmetic, slot pointer and result register.
  fmh_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .cmd_in_i     (cmd_i),
    .size_fx_i    (size_fx_i),
    .weight_i     (weight_i),
    .ascent_in_i  (ascent_in_i),
    .height_in_i  (height_in_i),
    .status_o     (status_o),
    .ascent_out_o (ascent_out_o),
    .height_out_o (height_out_o),
    .key_we_o     (key_we),
    .ram_addr_o   (ram_addr),
    .key_wdata_o  (key_wdata),
    .key_rdata_i  (key_rdata),
    .data_we_o    (data_we),
    .data_wdata_o (data_wdata),
    .data_rdata_i (data_rdata)
  );

  // Keys; zero marks an empty slot.
  fmh_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .addr_i  (ram_addr),
    .wdata_i (key_wdata),
    .rdata_o (key_rdata)
  );

  // Ascent in the upper word, line height in the lower word.
  fmh_ram #(
    .WIDTH (2*METRIC_W),
    .DEPTH (TABLE_SLOTS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .addr_i  (ram_addr),
    .wdata_i (data_wdata),
    .rdata_o (data_rdata)
  );

endmodule

`default_nettype wire

// ----- verif/font_metric_hash_cache_tb.sv -----
module font_metric_hash_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fmh_pkg::*;

  localparam logic CMD_LOOKUP = 1'b0;

  // Random part sizing: a pool of recurring keys keeps the table busy with hits,
  // updates and collisions before the fill phase pushes it to full.
  localparam int POOL_N     = 40;
  localparam int MIXED_N    = 260;
  localparam int FILL_N     = 80;
  localparam int TAIL_N     = 40;
  localparam int HOLD_AT    = 120;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 40;

  typedef struct packed {
    logic                cmd;
    logic [SIZE_W-1:0]   size;
    logic [WEIGHT_W-1:0] wgt;
    logic [METRIC_W-1:0] asc;
    logic [METRIC_W-1:0] hgt;
  } beat_t;

  typedef struct packed {
    status_e             st;
    logic [METRIC_W-1:0] asc;
    logic [METRIC_W-1:0] hgt;
  } metric_t;

  // One directed row: the beat, plus a hand-typed result where it is obvious.
  typedef struct packed {
    logic                cmd;
    logic [SIZE_W-1:0]   size;
    logic [WEIGHT_W-1:0] wgt;
    logic [METRIC_W-1:0] asc;
    logic [METRIC_W-1:0] hgt;
    logic                typed;
    status_e             st;
    logic [METRIC_W-1:0] asc_x;
    logic [METRIC_W-1:0] hgt_x;
  } row_t;

  localparam int DIR_N = 24;

  // Directed walk: empty table, the empty key, size saturation, rounding
  // half up at the 1/16 px boundary, update over an existing key, weight
  // as part of the key, metric extremes.
  row_t dir_tbl [DIR_N] = '{
    '{CMD_LOOKUP, 24'h000A00, 8'h90, 32'h0, 32'h0, 1'b1, ST_MISS, 32'h0, 32'h0},
    '{CMD_LOOKUP, 24'h000000, 8'h00, 32'h0, 32'h0, 1'b1, ST_MISS, 32'h0, 32'h0},
    '{CMD_INSERT, 24'h000007, 8'h00, 32'h11111111, 32'h22222222,
      1'b1, ST_STORED, 32'h0, 32'h0},
    '{CMD_LOOKUP, 24'h000000, 8'h00, 32'h0, 32'h0, 1'b1, ST_MISS, 32'h0, 32'h0},
    '{CMD_INSERT, 24'hFFFFFF, 8'hFF, 32'h7FFFFFFF, 32'h80000000,
      1'b1, ST_STORED, 32'h0, 32'h0},
    '{CMD_LOOKUP, 24'hFFFFFF, 8'hFF, 32'h0, 32'h0,
      1'b1, ST_HIT, 32'h7FFFFFFF, 32'h80000000},
    '{CMD_LOOKUP, 24'hFFFFF8, 8'hFF, 32'h0, 32'h0,
      1'b1, ST_HIT, 32'h7FFFFFFF, 32'h80000000},
    '{CMD_LOOKUP, 24'hFFFFE8, 8'hFF, 32'h0, 32'h0,
      1'b1, ST_HIT, 32'h7FFFFFFF, 32'h80000000},
    '{CMD_LOOKUP, 24'hFFFFE7, 8'hFF, 32'h0, 32'h0, 1'b1, ST_MISS, 32'h0, 32'h0},
    '{CMD_INSERT, 24'h000C08, 8'h00, 32'h80000000, 32'h7FFFFFFF,
      1'b1, ST_STORED, 32'h0, 32'h0},
    '{CMD_LOOKUP, 24'h000C07, 8'h00, 32'h0, 32'h0, 1'b1, ST_MISS, 32'h0, 32'h0},
    '{CMD_LOOKUP, 24'h000C17, 8'h00, 32'h0, 32'h0,
      1'b1, ST_HIT, 32'h80000000, 32'h7FFFFFFF},
    '{CMD_INSERT, 24'h000C10, 8'h00, 32'hFFFFFFFF, 32'h00000000,
      1'b1, ST_STORED, 32'h0, 32'h0},
    '{CMD_LOOKUP, 24'h000C08, 8'h00, 32'h0, 32'h0,
      1'b1, ST_HIT, 32'hFFFFFFFF, 32'h00000000},
    '{CMD_INSERT, 24'h123456, 8'h5A, 32'h00018000, 32'hFFFE0000,
      1'b1, ST_STORED, 32'h0, 32'h0},
    '{CMD_LOOKUP, 24'h123456, 8'h5A, 32'h0, 32'h0,
      1'b1, ST_HIT, 32'h00018000, 32'hFFFE0000},
    '{CMD_LOOKUP, 24'h123456, 8'hA5, 32'h0, 32'h0, 1'b1, ST_MISS, 32'h0, 32'h0},
    '{CMD_INSERT, 24'h000000, 8'h01, 32'h00000001, 32'hFFFFFFFF,
      1'b1, ST_STORED, 32'h0, 32'h0},
    '{CMD_LOOKUP, 24'h000003, 8'h01, 32'h0, 32'h0,
      1'b1, ST_HIT, 32'h00000001, 32'hFFFFFFFF},
    '{CMD_INSERT, 24'h000000, 8'h00, 32'h33333333, 32'h44444444,
      1'b1, ST_STORED, 32'h0, 32'h0},
    '{CMD_LOOKUP, 24'h000007, 8'h00, 32'h0, 32'h0, 1'b1, ST_MISS, 32'h0, 32'h0},
    '{CMD_INSERT, 24'hAAAAAA, 8'h55, 32'h55555555, 32'hAAAAAAAA,
      1'b0, ST_MISS, 32'h0, 32'h0},
    '{CMD_LOOKUP, 24'hAAAAAA, 8'h55, 32'h0, 32'h0, 1'b0, ST_MISS, 32'h0, 32'h0},
    '{CMD_LOOKUP, 24'h555555, 8'hAA, 32'h0, 32'h0, 1'b0, ST_MISS, 32'h0, 32'h0}
  };

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       cmd_i       = CMD_LOOKUP;
  logic [SIZE_W-1:0]          size_fx_i   = '0;
  logic [WEIGHT_W-1:0]        weight_i    = '0;
  logic signed [METRIC_W-1:0] ascent_in_i = '0;
  logic signed [METRIC_W-1:0] height_in_i = '0;
  logic                       out_ready_i = 1'b0;
  logic                       in_ready_o;
  logic                       out_valid_o;
  logic [STATUS_W-1:0]        status_o;
  logic signed [METRIC_W-1:0] ascent_out_o;
  logic signed [METRIC_W-1:0] height_out_o;

  // Shadow of the table contents, updated as each beat is accepted.
  logic [KEY_W-1:0]    key_mem [TABLE_SLOTS] = '{default: '0};
  logic [METRIC_W-1:0] asc_mem [TABLE_SLOTS] = '{default: '0};
  logic [METRIC_W-1:0] hgt_mem [TABLE_SLOTS] = '{default: '0};

  metric_t             metric_q [$];
  logic [SIZE_W-1:0]   pool_size [POOL_N];
  logic [WEIGHT_W-1:0] pool_wgt [POOL_N];

  bit idle_on    = 1'b1;
  int fail_cnt   = 0;
  int beats_seen = 0;
  int stall_left = 0;

  font_metric_hash_cache u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .size_fx_i    (size_fx_i),
    .weight_i     (weight_i),
    .ascent_in_i  (ascent_in_i),
    .height_in_i  (height_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .ascent_out_o (ascent_out_o),
    .height_out_o (height_out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // murmur3 fmix64 finalizer, low word only
  function automatic logic [31:0] fmix_lo(input logic [63:0] k);
    k = k ^ (k >> 33);
    k = k * FMIX_C1;
    k = k ^ (k >> 33);
    k = k * FMIX_C2;
    k = k ^ (k >> 33);
    return k[31:0];
  endfunction

  // Round size to 1/16 px (half up), saturate, then append the weight.
  function automatic logic [KEY_W-1:0] pack_key(input logic [SIZE_W-1:0] size,
                                                input logic [WEIGHT_W-1:0] wgt);
    logic [SIZE_W:0]  rnd;
    logic [QSIZE_W:0] q;
    rnd = {1'b0, size} + (SIZE_W+1)'(8);
    q   = rnd[SIZE_W:4];
    if (q[QSIZE_W]) q = {1'b0, {QSIZE_W{1'b1}}};
    return {q[QSIZE_W-1:0], wgt};
  endfunction

  // Walk the probe chain from the home slot and apply the beat to the shadow.
  function automatic metric_t probe_table(input beat_t b);
    logic [KEY_W-1:0]  key;
    logic [31:0]       h;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  cur;
    metric_t           r;
    bit                done;
    key   = pack_key(b.size, b.wgt);
    h     = fmix_lo(64'(key));
    slot  = h[SLOT_W-1:0];
    r.st  = (b.cmd == CMD_INSERT) ? ST_FULL : ST_MISS;
    r.asc = '0;
    r.hgt = '0;
    done  = 1'b0;
    for (int i = 0; i < TABLE_SLOTS && !done; i++) begin
      cur = key_mem[slot];
      if (b.cmd == CMD_INSERT) begin
        if (cur == '0 || cur == key) begin
          key_mem[slot] = key;
          asc_mem[slot] = b.asc;
          hgt_mem[slot] = b.hgt;
          r.st = ST_STORED;
          done = 1'b1;
        end
      end else if (cur == '0) begin
        done = 1'b1;
      end else if (cur == key) begin
        r.st  = ST_HIT;
        r.asc = asc_mem[slot];
        r.hgt = hgt_mem[slot];
        done  = 1'b1;
      end
      slot = (slot == SLOT_LAST) ? '0 : slot + 1'b1;
    end
    return r;
  endfunction

  // Another size in the same 1/16 px bucket; keep the size when none fits.
  function automatic logic [SIZE_W-1:0] bucket_twin(input logic [SIZE_W-1:0] s);
    logic [SIZE_W+1:0] lo;
    lo = ({2'b0, s} + 8) & ~26'hF;
    lo = lo - 8 + $urandom_range(0, 15);
    if (lo > 26'hFFFFFF) return s;
    return lo[SIZE_W-1:0];
  endfunction

  // Offer one beat, optionally after a gap, and record its expected result
  // at the edge where it is taken.
  task automatic send_beat(input beat_t b, input bit typed, input metric_t hand);
    int unsigned gap;
    metric_t     want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i       <= b.cmd;
    size_fx_i   <= b.size;
    weight_i    <= b.wgt;
    ascent_in_i <= b.asc;
    height_in_i <= b.hgt;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = probe_table(b);
    metric_q.push_back(typed ? hand : want);
  endtask

  // Result side: check each beat against the oldest expectation, stall in
  // random bursts, and hold off for a long stretch once mid-run.
  always @(posedge clk_i) begin
    metric_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (metric_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("unexpected result beat: status %0d ascent %h height %h",
                     status_o, ascent_out_o, height_out_o);
          fail_cnt++;
        end else begin
          want = metric_q.pop_front();
          if (status_o !== want.st || ascent_out_o !== want.asc ||
              height_out_o !== want.hgt) begin
            if (fail_cnt < 10)
              $display("result %0d mismatch: status exp %0d got %0d, ascent exp %h got %h, height exp %h got %h",
                       beats_seen, want.st, status_o, want.asc, ascent_out_o,
                       want.hgt, height_out_o);
            fail_cnt++;
          end
        end
        beats_seen++;
        // Back-pressure all the way to the input while the sender keeps going.
        if (beats_seen == HOLD_AT) stall_left = HOLD_LEN;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #600us;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    beat_t   b;
    metric_t hand;
    int      p;

    for (int i = 0; i < POOL_N; i++) begin
      case ($urandom_range(0, 2))
        0:       pool_size[i] = $urandom();
        1:       pool_size[i] = $urandom_range(0, 16'hFFFF);
        default: pool_size[i] = $urandom_range(24'hFFFF00, 24'hFFFFFF);
      endcase
      pool_wgt[i] = $urandom_range(0, 255);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows; the block's clearing sweep simply holds off the first one.
    for (int i = 0; i < DIR_N; i++) begin
      b    = '{dir_tbl[i].cmd, dir_tbl[i].size, dir_tbl[i].wgt,
               dir_tbl[i].asc, dir_tbl[i].hgt};
      hand = '{dir_tbl[i].st, dir_tbl[i].asc_x, dir_tbl[i].hgt_x};
      send_beat(b, dir_tbl[i].typed, hand);
    end

    // Mostly recurring keys with fresh random metrics; some fresh keys and
    // same-bucket lookups mixed in. Idling is switched per segment.
    for (int n = 0; n < MIXED_N; n++) begin
      if (n % 40 == 0) idle_on <= ($urandom_range(0, 2) != 0);
      p      = $urandom_range(0, POOL_N - 1);
      b.cmd  = $urandom_range(0, 1) ? CMD_INSERT : CMD_LOOKUP;
      b.size = pool_size[p];
      b.wgt  = pool_wgt[p];
      if (b.cmd == CMD_LOOKUP && $urandom_range(0, 3) == 0) b.size = bucket_twin(b.size);
      if ($urandom_range(0, 9) == 0) begin
        b.size = $urandom();
        b.wgt  = $urandom();
      end
      b.asc = $urandom();
      b.hgt = $urandom();
      send_beat(b, 1'b0, '0);
    end

    // Tail without idling: fill the table, then drive drops and full-table
    // misses next to pool hits.
    idle_on <= 1'b0;
    for (int n = 0; n < FILL_N; n++) begin
      b = '{CMD_INSERT, SIZE_W'($urandom()), WEIGHT_W'($urandom()),
            METRIC_W'($urandom()), METRIC_W'($urandom())};
      send_beat(b, 1'b0, '0);
    end
    b = '{CMD_INSERT, 24'h000005, 8'h00, 32'h5A5A5A5A, 32'hA5A5A5A5};
    send_beat(b, 1'b0, '0);
    for (int n = 0; n < TAIL_N; n++) begin
      b.cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_LOOKUP;
      if ($urandom_range(0, 1)) begin
        p      = $urandom_range(0, POOL_N - 1);
        b.size = pool_size[p];
        b.wgt  = pool_wgt[p];
      end else begin
        b.size = $urandom();
        b.wgt  = $urandom();
      end
      b.asc = $urandom();
      b.hgt = $urandom();
      send_beat(b, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Drain, then give any stray beat time to show up.
    while (metric_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fmh_pkg.sv
rtl/fmh_ram.sv
rtl/fmh_dp.sv
rtl/fmh_ctrl.sv
rtl/font_metric_hash_cache.sv
verif/font_metric_hash_cache_tb.sv
